// ===== sv/axle_speed_trap_classifier_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the axle speed trap classifier
// Implication checks sampled on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef AXLE_SPEED_TRAP_CLASSIFIER_ASSERT_SVH
`define AXLE_SPEED_TRAP_CLASSIFIER_ASSERT_SVH

// same-cycle implication
`define ASTC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("astc assertion failed");

// next-cycle implication
`define ASTC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("astc assertion failed");

`endif

// ===== sv/astc_pkg.sv =====
// ----------------------------------------------------------------------------
// astc_pkg
// Types and constants shared by the axle speed trap classifier modules.
// ----------------------------------------------------------------------------
package astc_pkg;

  typedef enum logic {
    OP_TICK  = 1'b0,
    OP_SENSE = 1'b1
  } opcode_t;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  localparam logic [CFG_IDX_W-1:0] CFG_SPACING  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TRUCK    = 2'd3;

  localparam logic [7:0] SPACING_RST  = 8'd30;
  localparam logic [7:0] LIMIT_RST    = 8'd60;
  localparam logic [9:0] DEBOUNCE_RST = 10'd10;
  localparam logic [3:0] TRUCK_RST    = 4'd2;

  // cm/ms to km/h
  localparam logic [5:0] SPEED_FACTOR = 6'd36;
  localparam logic [9:0] HOLD_MAX     = 10'd1023;

  typedef struct packed {
    opcode_t opcode;
    logic    loop_present;
    logic    piezo_a;
    logic    piezo_b;
  } item_t;

  typedef struct packed {
    logic        camera_trigger;
    logic        speeding;
    logic [31:0] car_count;
    logic [31:0] truck_count;
    logic [7:0]  vehicle_axles;
    logic [15:0] transit_ms;
  } result_t;

  // handshake status between the pipeline stages
  typedef struct packed {
    logic advance;  // stage 1 request moves into the result register
    logic space;    // result register can take a request this cycle
  } pipe_ctl_t;

endpackage

// ===== sv/astc_in_stage.sv =====
// ----------------------------------------------------------------------------
// astc_in_stage
// Input register: captures one sensor request and holds it until processed.
// ----------------------------------------------------------------------------
module astc_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  astc_pkg::item_t   in_item,
  input  astc_pkg::pipe_ctl_t ctl,
  output logic              s1_valid,
  output astc_pkg::item_t   s1_item
);

  logic            s1_valid_r;
  astc_pkg::item_t s1_item_r;

  assign in_ready = !s1_valid_r || ctl.space;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid_r <= 1'b1;
    end else if (ctl.advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r <= in_item;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_item  = s1_item_r;

endmodule

// ===== sv/astc_core.sv =====
// ----------------------------------------------------------------------------
// astc_core
// Configuration, vehicle state and the single-pass update for one request.
// ----------------------------------------------------------------------------
module astc_core #(
  parameter int COUNT_WIDTH = 32,
  parameter int MS_WIDTH    = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [astc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [astc_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                                fire,
  input  astc_pkg::item_t                     item,
  output astc_pkg::result_t                   res
);

  localparam int PROD_W = MS_WIDTH + 8;
  localparam logic [MS_WIDTH-1:0] MS_MAX = {MS_WIDTH{1'b1}};

  logic [7:0] spacing_r, limit_r;
  logic [9:0] debounce_r;
  logic [3:0] truck_min_r;

  logic                   timer_r, timer_nxt;
  logic [MS_WIDTH-1:0]    elapsed_r, elapsed_nxt;
  logic                   cam_r, cam_nxt;
  logic [7:0]             axles_a_r, axles_a_nxt;
  logic [7:0]             axles_b_r, axles_b_nxt;
  logic [7:0]             last_axles_r, last_axles_nxt;
  logic [COUNT_WIDTH-1:0] cars_r, cars_nxt;
  logic [COUNT_WIDTH-1:0] trucks_r, trucks_nxt;
  logic                   hold_a_r, hold_a_nxt;
  logic                   hold_b_r, hold_b_nxt;
  logic [9:0]             hold_cnt_a_r, hold_cnt_a_nxt;
  logic [9:0]             hold_cnt_b_r, hold_cnt_b_nxt;
  logic [15:0]            last_transit_r, last_transit_nxt;
  logic                   speeding;

  logic [PROD_W-1:0] lhs, rhs;
  logic              over_limit;
  logic [31:0]       elapsed_ext;
  logic [63:0]       cars_ext, trucks_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spacing_r   <= astc_pkg::SPACING_RST;
      limit_r     <= astc_pkg::LIMIT_RST;
      debounce_r  <= astc_pkg::DEBOUNCE_RST;
      truck_min_r <= astc_pkg::TRUCK_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        astc_pkg::CFG_SPACING:  spacing_r   <= cfg_wdata[7:0];
        astc_pkg::CFG_LIMIT:    limit_r     <= cfg_wdata[7:0];
        astc_pkg::CFG_DEBOUNCE: debounce_r  <= cfg_wdata;
        astc_pkg::CFG_TRUCK:    truck_min_r <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  // speed test: spacing * 36 > limit * elapsed
  assign lhs         = PROD_W'(spacing_r) * PROD_W'(astc_pkg::SPEED_FACTOR);
  assign rhs         = PROD_W'(limit_r) * PROD_W'(elapsed_r);
  assign over_limit  = lhs > rhs;
  assign elapsed_ext = 32'(elapsed_r);

  always_comb begin
    timer_nxt        = timer_r;
    elapsed_nxt      = elapsed_r;
    cam_nxt          = cam_r;
    axles_a_nxt      = axles_a_r;
    axles_b_nxt      = axles_b_r;
    last_axles_nxt   = last_axles_r;
    cars_nxt         = cars_r;
    trucks_nxt       = trucks_r;
    hold_a_nxt       = hold_a_r;
    hold_b_nxt       = hold_b_r;
    hold_cnt_a_nxt   = hold_cnt_a_r;
    hold_cnt_b_nxt   = hold_cnt_b_r;
    last_transit_nxt = last_transit_r;
    speeding         = 1'b0;

    if (item.opcode == astc_pkg::OP_TICK) begin
      if (timer_r && elapsed_r != MS_MAX) begin
        elapsed_nxt = elapsed_r + 1'b1;
      end
      if (cam_r) begin
        cam_nxt     = 1'b0;
        timer_nxt   = 1'b0;
        elapsed_nxt = '0;
      end
      if (hold_a_r) begin
        if (hold_cnt_a_r != astc_pkg::HOLD_MAX) begin
          hold_cnt_a_nxt = hold_cnt_a_r + 1'b1;
        end
        if (hold_cnt_a_nxt >= debounce_r) begin
          hold_a_nxt = 1'b0;
        end
      end
      if (hold_b_r) begin
        if (hold_cnt_b_r != astc_pkg::HOLD_MAX) begin
          hold_cnt_b_nxt = hold_cnt_b_r + 1'b1;
        end
        if (hold_cnt_b_nxt >= debounce_r) begin
          hold_b_nxt = 1'b0;
        end
      end
    end else if (item.loop_present) begin
      if (item.piezo_a) begin
        if (axles_a_r == 8'd0) begin
          timer_nxt = 1'b1;
          cars_nxt  = cars_r + 1'b1;
        end
        if (!hold_a_r) begin
          hold_a_nxt     = 1'b1;
          hold_cnt_a_nxt = '0;
          axles_a_nxt    = axles_a_r + 1'b1;
        end
      end
      if (item.piezo_b) begin
        if (axles_b_r == 8'd0) begin
          timer_nxt        = 1'b0;
          last_transit_nxt = elapsed_ext[15:0];
          if (elapsed_r == '0) begin
            // zero transit: drop the vehicle
            axles_a_nxt    = '0;
            axles_b_nxt    = '0;
            last_axles_nxt = '0;
          end else if (over_limit) begin
            cam_nxt   = 1'b1;
            timer_nxt = 1'b1;
            speeding  = 1'b1;
          end
          elapsed_nxt = '0;
        end
        if (!hold_b_r) begin
          hold_b_nxt     = 1'b1;
          hold_cnt_b_nxt = '0;
          axles_b_nxt    = axles_b_nxt + 1'b1;
        end
      end
    end else if (axles_a_r != 8'd0) begin
      // loop cleared: close the vehicle
      last_axles_nxt = axles_a_r;
      if (axles_a_r > {4'd0, truck_min_r}) begin
        cars_nxt   = cars_r - 1'b1;
        trucks_nxt = trucks_r + 1'b1;
      end
      axles_a_nxt = '0;
      axles_b_nxt = '0;
      elapsed_nxt = '0;
      timer_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timer_r        <= 1'b0;
      elapsed_r      <= '0;
      cam_r          <= 1'b0;
      axles_a_r      <= '0;
      axles_b_r      <= '0;
      last_axles_r   <= '0;
      cars_r         <= '0;
      trucks_r       <= '0;
      hold_a_r       <= 1'b0;
      hold_b_r       <= 1'b0;
      hold_cnt_a_r   <= '0;
      hold_cnt_b_r   <= '0;
      last_transit_r <= '0;
    end else if (fire) begin
      timer_r        <= timer_nxt;
      elapsed_r      <= elapsed_nxt;
      cam_r          <= cam_nxt;
      axles_a_r      <= axles_a_nxt;
      axles_b_r      <= axles_b_nxt;
      last_axles_r   <= last_axles_nxt;
      cars_r         <= cars_nxt;
      trucks_r       <= trucks_nxt;
      hold_a_r       <= hold_a_nxt;
      hold_b_r       <= hold_b_nxt;
      hold_cnt_a_r   <= hold_cnt_a_nxt;
      hold_cnt_b_r   <= hold_cnt_b_nxt;
      last_transit_r <= last_transit_nxt;
    end
  end

  assign cars_ext   = 64'(cars_nxt);
  assign trucks_ext = 64'(trucks_nxt);

  assign res.camera_trigger = cam_nxt;
  assign res.speeding       = speeding;
  assign res.car_count      = cars_ext[31:0];
  assign res.truck_count    = trucks_ext[31:0];
  assign res.vehicle_axles  = last_axles_nxt;
  assign res.transit_ms     = last_transit_nxt;

endmodule

// ===== sv/astc_out_stage.sv =====
// ----------------------------------------------------------------------------
// astc_out_stage
// Result register: holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module astc_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  astc_pkg::result_t res,
  output logic              space,
  output logic              out_valid,
  input  logic              out_ready,
  output astc_pkg::result_t out_res
);

  logic              out_valid_r;
  astc_pkg::result_t out_res_r;

  assign space = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_res_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

// ===== sv/axle_speed_trap_classifier.sv =====
// ----------------------------------------------------------------------------
// axle_speed_trap_classifier: lane axle counter and speed trap
// Throughput: one request per cycle while out_ready keeps the result register drained.
// Input and result are registered; the state update is one pass of compare/count logic.
// Reset: synchronous on rst_n low; config returns to defaults, counters and state to zero.
// ----------------------------------------------------------------------------
`include "axle_speed_trap_classifier_assert.svh"

module axle_speed_trap_classifier #(
  parameter int COUNT_WIDTH = 32,
  parameter int MS_WIDTH    = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [astc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [astc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_opcode,
  input  logic                            in_loop_present,
  input  logic                            in_piezo_a,
  input  logic                            in_piezo_b,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_camera_trigger,
  output logic                            out_speeding,
  output logic [31:0]                     out_car_count,
  output logic [31:0]                     out_truck_count,
  output logic [7:0]                      out_vehicle_axles,
  output logic [15:0]                     out_transit_ms
);

  astc_pkg::item_t     in_item, s1_item;
  astc_pkg::result_t   res, out_res;
  astc_pkg::pipe_ctl_t ctl;
  logic                s1_valid;
  logic                space;

  assign in_item.opcode       = astc_pkg::opcode_t'(in_opcode);
  assign in_item.loop_present = in_loop_present;
  assign in_item.piezo_a      = in_piezo_a;
  assign in_item.piezo_b      = in_piezo_b;

  assign ctl.space   = space;
  assign ctl.advance = s1_valid && space;

  astc_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .ctl      (ctl),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  astc_core #(
    .COUNT_WIDTH (COUNT_WIDTH),
    .MS_WIDTH    (MS_WIDTH)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .fire      (ctl.advance),
    .item      (s1_item),
    .res       (res)
  );

  astc_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (ctl.advance),
    .res       (res),
    .space     (space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_camera_trigger = out_res.camera_trigger;
  assign out_speeding       = out_res.speeding;
  assign out_car_count      = out_res.car_count;
  assign out_truck_count    = out_res.truck_count;
  assign out_vehicle_axles  = out_res.vehicle_axles;
  assign out_transit_ms     = out_res.transit_ms;

  // a speeding transit always raises the camera
  `ASTC_ASSERT_NOW(a_speed_cam, out_valid && out_speeding, out_camera_trigger)
  // an empty result register never back-pressures the input
  `ASTC_ASSERT_NOW(a_ready_empty, !out_valid, in_ready)
  // a tick never reports a speeding transit
  `ASTC_ASSERT_NOW(a_tick_no_speed,
                   ctl.advance && s1_item.opcode == astc_pkg::OP_TICK, !res.speeding)
  // a processed request is visible in the next cycle
  `ASTC_ASSERT_NEXT(a_load_valid, ctl.advance, out_valid)

endmodule
